>>> hdl/cgfu_pkg.sv
// shared constants and types for the correlated gaussian generator
// no dependencies; imported by cgfu_gauss, correlated_gaussian_from_uniform and the testbench
`default_nettype none

package cgfu_pkg;

	localparam int CGFU_LANES = 8;
	localparam int GAUSS_LAT  = 41;

	// central-region rational coefficients, Q.24
	localparam logic signed [35:0] COEF_A [6] = '{
		-36'sd666002296,
		 36'sd3706860418,
		-36'sd4629312220,
		 36'sd2321257888,
		-36'sd514469941,
		 36'sd42054244
	};

	localparam logic signed [35:0] COEF_B [5] = '{
		-36'sd913957276,
		 36'sd2710960488,
		-36'sd2612195416,
		 36'sd1120740039,
		-36'sd222812863
	};

	localparam logic signed [35:0] ONE_Q24 = 36'sd16777216;
	localparam logic signed [31:0] G_MAX   = 32'sh7fffffff;
	localparam logic signed [31:0] G_MIN   = 32'sh80000000;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         idx;
		logic signed [17:0] val;
	} item_t;

	typedef struct packed {
		logic [7:0][31:0] val;
		logic             sat;
	} res_t;

endpackage

`default_nettype wire

>>> hdl/cgfu_gauss.sv
// one lane: uniform to gaussian, horner stages then a bit-per-stage divider
// depends on cgfu_pkg
`default_nettype none

module cgfu_gauss
	import cgfu_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [23:0]        u,
	output logic signed [31:0] g,
	output logic               sat
);

	typedef struct packed {
		logic neg;
		logic num_neg;
		logic num_nz;
		logic dzero;
		logic ovf;
	} div_info_t;

	logic signed [23:0] z_in;
	logic signed [47:0] zz_in;

	logic signed [23:0] z_s1;
	logic [22:0]        r_s1;

	logic signed [59:0] hp_s [2:6];
	logic signed [59:0] hq_s [2:6];
	logic signed [23:0] hz_s [2:6];
	logic [22:0]        hr_s [2:6];

	logic signed [59:0] np_s7;
	logic signed [35:0] den_s7;

	logic signed [35:0] num_c;
	logic [35:0]        nmag_c;
	logic [35:0]        dmag_c;

	logic [59:0]  rem_d  [0:32];
	logic [31:0]  quo_d  [0:32];
	logic [35:0]  dmag_d [0:32];
	div_info_t    info_d [0:32];

	logic signed [31:0] g_s;
	logic               sat_s;

	assign z_in  = {~u[23], u[22:0]};
	assign zz_in = z_in * z_in;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= z_in;
			r_s1 <= zz_in[46:24];
			hz_s[2] <= z_s1;
			hr_s[2] <= r_s1;
			hp_s[2] <= COEF_A[0] * $signed({1'b0, r_s1});
			hq_s[2] <= COEF_B[0] * $signed({1'b0, r_s1});
		end
	end

	for (genvar k = 3; k <= 6; k++) begin : g_horner
		logic signed [35:0] p_c;
		logic signed [35:0] q_c;
		assign p_c = $signed(hp_s[k-1][59:24]) + COEF_A[k-2];
		assign q_c = $signed(hq_s[k-1][59:24]) + COEF_B[k-2];
		always_ff @(posedge clk) begin
			if (en) begin
				hz_s[k] <= hz_s[k-1];
				hr_s[k] <= hr_s[k-1];
				hp_s[k] <= p_c * $signed({1'b0, hr_s[k-1]});
				hq_s[k] <= q_c * $signed({1'b0, hr_s[k-1]});
			end
		end
	end

	logic signed [35:0] p5_c;
	assign p5_c = $signed(hp_s[6][59:24]) + COEF_A[5];

	always_ff @(posedge clk) begin
		if (en) begin
			np_s7  <= p5_c * hz_s[6];
			den_s7 <= $signed(hq_s[6][59:24]) + ONE_Q24;
		end
	end

	// sign and magnitude ahead of the divider
	assign num_c  = $signed(np_s7[59:24]);
	assign nmag_c = num_c[35] ? 36'(-num_c) : 36'(num_c);
	assign dmag_c = den_s7[35] ? 36'(-den_s7) : 36'(den_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_d[0]          <= {nmag_c, 24'b0};
			quo_d[0]          <= '0;
			dmag_d[0]         <= dmag_c;
			info_d[0].neg     <= num_c[35] ^ den_s7[35];
			info_d[0].num_neg <= num_c[35];
			info_d[0].num_nz  <= (num_c != '0);
			info_d[0].dzero   <= (den_s7 == '0);
			info_d[0].ovf     <= ({8'b0, nmag_c} >= {dmag_c, 8'b0});
		end
	end

	for (genvar j = 0; j < 32; j++) begin : g_div
		localparam logic [31:0] QBIT = 32'(1) << (31 - j);
		logic [67:0] trial;
		assign trial = {8'b0, rem_d[j]} - ({32'b0, dmag_d[j]} << (31 - j));
		always_ff @(posedge clk) begin
			if (en) begin
				dmag_d[j+1] <= dmag_d[j];
				info_d[j+1] <= info_d[j];
				if (!trial[67]) begin
					rem_d[j+1] <= trial[59:0];
					quo_d[j+1] <= quo_d[j] | QBIT;
				end else begin
					rem_d[j+1] <= rem_d[j];
					quo_d[j+1] <= quo_d[j];
				end
			end
		end
	end

	// sign, clip and zero-divisor handling
	always_ff @(posedge clk) begin
		if (en) begin
			if (info_d[32].dzero) begin
				sat_s <= 1'b1;
				if (!info_d[32].num_nz)
					g_s <= '0;
				else
					g_s <= info_d[32].num_neg ? G_MIN : G_MAX;
			end else if (info_d[32].ovf) begin
				sat_s <= 1'b1;
				g_s   <= info_d[32].neg ? G_MIN : G_MAX;
			end else if (!info_d[32].neg) begin
				sat_s <= quo_d[32][31];
				g_s   <= quo_d[32][31] ? G_MAX : $signed(quo_d[32]);
			end else begin
				sat_s <= (quo_d[32] > 32'h80000000);
				g_s   <= (quo_d[32] > 32'h80000000) ? G_MIN : $signed(-quo_d[32]);
			end
		end
	end

	assign g   = g_s;
	assign sat = sat_s;

endmodule

`default_nettype wire

>>> hdl/correlated_gaussian_from_uniform.sv
// Correlated gaussian generator. A beat with cmd low writes one Q1.16 coefficient
// of the 8x8 matrix and returns nothing; a beat with cmd high turns eight Q0.24
// uniforms into gaussians and returns the matrix-vector product in Q7.24 with a
// saturation flag. One beat is taken every cycle while in_ready is high; a result
// passes through the 41-stage lane pipeline (horner stages and a one-bit-per-stage
// divider), then three stages of multiply and adder tree, then the output buffer.
// Coefficient writes travel the same pipeline and take effect in beat order.
// A two-entry output buffer keeps input beats flowing while a result waits.
// depends on cgfu_pkg and cgfu_gauss
`default_nettype none

module correlated_gaussian_from_uniform
	import cgfu_pkg::*;
#(
	parameter int LANES = CGFU_LANES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [5:0]         coef_index,
	input  logic signed [17:0] coef_value,
	input  logic [23:0]        u0,
	input  logic [23:0]        u1,
	input  logic [23:0]        u2,
	input  logic [23:0]        u3,
	input  logic [23:0]        u4,
	input  logic [23:0]        u5,
	input  logic [23:0]        u6,
	input  logic [23:0]        u7,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out0,
	output logic signed [31:0] out1,
	output logic signed [31:0] out2,
	output logic signed [31:0] out3,
	output logic signed [31:0] out4,
	output logic signed [31:0] out5,
	output logic signed [31:0] out6,
	output logic signed [31:0] out7,
	output logic               saturated
);

	logic               en;
	logic [23:0]        u_lane [8];
	logic signed [31:0] g_lane [8];
	logic               sat_lane [8];

	item_t tag_s [GAUSS_LAT];
	logic  vld_s [GAUSS_LAT];

	logic signed [17:0] coef_q [64];

	logic signed [49:0] prod_d  [8][8];
	logic signed [49:0] prod_m1 [8][8];
	logic signed [50:0] sum_m2  [8][4];
	logic signed [51:0] sum_m3  [8][2];
	logic               v_m1, v_m2, v_m3;
	logic               f_m1, f_m2, f_m3;
	logic               f_d;

	res_t       res_c;
	res_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;

	assign u_lane[0] = u0;
	assign u_lane[1] = u1;
	assign u_lane[2] = u2;
	assign u_lane[3] = u3;
	assign u_lane[4] = u4;
	assign u_lane[5] = u5;
	assign u_lane[6] = u6;
	assign u_lane[7] = u7;

	for (genvar l = 0; l < 8; l++) begin : g_lane_inst
		if (l < LANES) begin : g_on
			cgfu_gauss u_gauss (
				.clk (clk),
				.en  (en),
				.u   (u_lane[l]),
				.g   (g_lane[l]),
				.sat (sat_lane[l])
			);
		end else begin : g_off
			assign g_lane[l]   = '0;
			assign sat_lane[l] = 1'b0;
		end
	end

	// beat tags ride alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < GAUSS_LAT; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < GAUSS_LAT; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0].cmd <= cmd;
			tag_s[0].idx <= coef_index;
			tag_s[0].val <= coef_value;
			for (int k = 1; k < GAUSS_LAT; k++)
				tag_s[k] <= tag_s[k-1];
		end
	end

	// coefficient store, written where the matrix is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 64; i++)
				coef_q[i] <= '0;
		end else if (en && vld_s[GAUSS_LAT-1] && tag_s[GAUSS_LAT-1].cmd == CMD_LOAD) begin
			coef_q[tag_s[GAUSS_LAT-1].idx] <= tag_s[GAUSS_LAT-1].val;
		end
	end

	for (genvar r = 0; r < 8; r++) begin : g_row
		for (genvar c = 0; c < 8; c++) begin : g_col
			localparam int IDX = r * 8 + c;
			if (r < LANES && c < LANES) begin : g_mul
				assign prod_d[r][c] = coef_q[IDX] * g_lane[c];
			end else begin : g_zero
				assign prod_d[r][c] = '0;
			end
		end
	end

	always_comb begin
		f_d = 1'b0;
		for (int l = 0; l < 8; l++)
			f_d = f_d | sat_lane[l];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
		end else if (en) begin
			v_m1 <= vld_s[GAUSS_LAT-1] && tag_s[GAUSS_LAT-1].cmd == CMD_SAMPLE;
			v_m2 <= v_m1;
			v_m3 <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_m1 <= f_d;
			f_m2 <= f_m1;
			f_m3 <= f_m2;
			for (int r = 0; r < 8; r++) begin
				for (int c = 0; c < 8; c++)
					prod_m1[r][c] <= prod_d[r][c];
				for (int k = 0; k < 4; k++)
					sum_m2[r][k] <= 51'(prod_m1[r][2*k]) + 51'(prod_m1[r][2*k+1]);
				for (int k = 0; k < 2; k++)
					sum_m3[r][k] <= 52'(sum_m2[r][2*k]) + 52'(sum_m2[r][2*k+1]);
			end
		end
	end

	// final add, scale and clip
	always_comb begin
		logic signed [52:0] acc;
		logic signed [36:0] sh;
		res_c.sat = f_m3;
		for (int r = 0; r < 8; r++) begin
			acc = 53'(sum_m3[r][0]) + 53'(sum_m3[r][1]);
			sh  = acc[52:16];
			if (sh > 37'(G_MAX)) begin
				res_c.val[r] = G_MAX;
				res_c.sat    = 1'b1;
			end else if (sh < 37'(G_MIN)) begin
				res_c.val[r] = G_MIN;
				res_c.sat    = 1'b1;
			end else begin
				res_c.val[r] = sh[31:0];
			end
		end
	end

	assign push = en && v_m3;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out0      = fifo_q[rd_ptr_q].val[0];
	assign out1      = fifo_q[rd_ptr_q].val[1];
	assign out2      = fifo_q[rd_ptr_q].val[2];
	assign out3      = fifo_q[rd_ptr_q].val[3];
	assign out4      = fifo_q[rd_ptr_q].val[4];
	assign out5      = fifo_q[rd_ptr_q].val[5];
	assign out6      = fifo_q[rd_ptr_q].val[6];
	assign out7      = fifo_q[rd_ptr_q].val[7];
	assign saturated = fifo_q[rd_ptr_q].sat;

endmodule

`default_nettype wire

>>> hdl/cgfu_check.sv
// port-level checks for the correlated gaussian generator, bound to the top level
// depends on correlated_gaussian_from_uniform
`default_nettype none

module cgfu_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out0,
	input logic [31:0] out1,
	input logic [31:0] out2,
	input logic [31:0] out3,
	input logic [31:0] out4,
	input logic [31:0] out5,
	input logic [31:0] out6,
	input logic [31:0] out7,
	input logic        saturated
);

	// a waiting result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out0) && $stable(out1)
			&& $stable(out2) && $stable(out3) && $stable(out4) && $stable(out5)
			&& $stable(out6) && $stable(out7) && $stable(saturated))
		else $error("result beat changed while stalled");

	// input backpressure only with a result waiting
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// ready drops only after an unaccepted result
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("input ready fell without output stall");

	// nothing comes out right after reset
	a_reset_quiet: assert property (@(posedge clk)
		$past(!arst_n) |-> !out_valid)
		else $error("result beat right after reset");

endmodule

bind correlated_gaussian_from_uniform cgfu_check u_cgfu_check (.*);

`default_nettype wire

>>> sim/correlated_gaussian_from_uniform_tb.sv
// self-checking testbench for correlated_gaussian_from_uniform: coefficient loads and
// sample beats under random idling, checked against an in-bench fixed-point predictor
// depends on cgfu_pkg and the correlated_gaussian_from_uniform rtl
`timescale 1ns / 100ps

module correlated_gaussian_from_uniform_tb;
	import cgfu_pkg::*;

	typedef struct {
		logic signed [31:0] lane [8];
		logic               sat;
	} gauss_vec_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic [5:0]         coef_index;
	logic signed [17:0] coef_value;
	logic [23:0]        u0, u1, u2, u3, u4, u5, u6, u7;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] out0, out1, out2, out3, out4, out5, out6, out7;
	logic               saturated;

	correlated_gaussian_from_uniform uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .coef_index(coef_index), .coef_value(coef_value),
		.u0(u0), .u1(u1), .u2(u2), .u3(u3), .u4(u4), .u5(u5), .u6(u6), .u7(u7),
		.out_valid(out_valid), .out_ready(out_ready),
		.out0(out0), .out1(out1), .out2(out2), .out3(out3),
		.out4(out4), .out5(out5), .out6(out6), .out7(out7),
		.saturated(saturated)
	);

	localparam int CYCLE_LIMIT = 400000;
	localparam longint G_HI = 64'sd2147483647;
	localparam longint G_LO = -64'sd2147483648;

	longint             horner_p [6];
	longint             horner_q [5];
	logic signed [17:0] matrix [64];
	gauss_vec_t         pending [$];
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 recv_hold;
	int                 errors;
	int                 cycles;

	function automatic longint q24_const(input longint unsigned ip,
		input longint unsigned fr, input bit neg);
		logic [127:0] t;
		t = 128'(fr) * 128'd16777216 + 128'd500000000000;
		t = t / 128'd1000000000000;
		t = t + 128'(ip) * 128'd16777216;
		return neg ? -longint'(t[63:0]) : longint'(t[63:0]);
	endfunction

	function automatic longint clip_q824(input longint x, inout bit sat);
		if (x > G_HI) begin
			sat = 1;
			return G_HI;
		end
		if (x < G_LO) begin
			sat = 1;
			return G_LO;
		end
		return x;
	endfunction

	function automatic longint inv_cdf(input logic [23:0] u, inout bit sat);
		longint z, r, p, q, num;
		z = longint'({40'd0, u}) - 64'sd8388608;
		r = (z * z) >>> 24;
		p = horner_p[0];
		for (int i = 1; i < 6; i++)
			p = ((p * r) >>> 24) + horner_p[i];
		num = (p * z) >>> 24;
		q = horner_q[0];
		for (int i = 1; i < 5; i++)
			q = ((q * r) >>> 24) + horner_q[i];
		q = ((q * r) >>> 24) + 64'sd16777216;
		if (q == 0) begin
			sat = 1;
			return (num > 0) ? G_HI : (num < 0) ? G_LO : 0;
		end
		return clip_q824((num * 64'sd16777216) / q, sat);
	endfunction

	function automatic gauss_vec_t correlate(input logic [23:0] uv [8]);
		gauss_vec_t res;
		longint g [8];
		longint acc;
		bit sat;
		sat = 0;
		for (int c = 0; c < 8; c++)
			g[c] = inv_cdf(uv[c], sat);
		for (int row = 0; row < 8; row++) begin
			acc = 0;
			for (int c = 0; c < 8; c++)
				acc += longint'(matrix[row * 8 + c]) * g[c];
			res.lane[row] = 32'(clip_q824(acc >>> 16, sat));
		end
		res.sat = sat;
		return res;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("correlated_gaussian_from_uniform_tb NOT OK");
			$finish;
		end
	end

	// receiver: random stalls plus long hold-off on request
	always @(posedge clk) begin
		if (recv_hold > 0) begin
			recv_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		gauss_vec_t exp_v;
		logic signed [31:0] act [8];
		if (arst_n && out_valid && out_ready) begin
			act = '{out0, out1, out2, out3, out4, out5, out6, out7};
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				exp_v = pending.pop_front();
				for (int i = 0; i < 8; i++)
					if (act[i] !== exp_v.lane[i]) begin
						$error("out%0d expected %0d actual %0d", i, exp_v.lane[i], act[i]);
						errors++;
					end
				if (saturated !== exp_v.sat) begin
					$error("saturated expected %0d actual %0d", exp_v.sat, saturated);
					errors++;
				end
			end
		end
	end

	task automatic send_beat(input logic c, input logic [5:0] idx,
		input logic signed [17:0] val, input logic [23:0] uv [8]);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		coef_index <= idx;
		coef_value <= val;
		{u0, u1, u2, u3, u4, u5, u6, u7} <= {uv[0], uv[1], uv[2], uv[3],
			uv[4], uv[5], uv[6], uv[7]};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (c == CMD_LOAD)
			matrix[idx] = val;
		else
			pending.push_back(correlate(uv));
	endtask

	task automatic load_coef(input int idx, input logic signed [17:0] val);
		logic [23:0] uv [8];
		foreach (uv[i]) uv[i] = $urandom;
		send_beat(CMD_LOAD, 6'(idx), val, uv);
	endtask

	task automatic sample_all(input logic [23:0] v);
		logic [23:0] uv [8];
		foreach (uv[i]) uv[i] = v;
		send_beat(CMD_SAMPLE, 6'($urandom), 18'($urandom), uv);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		wait (pending.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic test_cleared_matrix;
		sample_all(24'h000000);
		sample_all(24'h3a5c11);
	endtask

	task automatic test_identity_extremes;
		for (int i = 0; i < 8; i++)
			load_coef(i * 9, 18'sd65536);
		sample_all(24'h000000);
		sample_all(24'hffffff);
		sample_all(24'h800000);
		sample_all(24'h000001);
		sample_all(24'h7fffff);
	endtask

	task automatic test_coef_saturation;
		load_coef(0, 18'sh1ffff);
		load_coef(1, 18'sh1ffff);
		load_coef(9, -18'sd131072);
		load_coef(8, -18'sd131072);
		load_coef(63, -18'sd131072);
		sample_all(24'hffffff);
		sample_all(24'h000000);
		sample_all(24'hf00000);
	endtask

	task automatic test_random(input int n, input int sp, input int rp);
		logic [23:0] uv [8];
		send_idle_pct = sp;
		recv_idle_pct = rp;
		for (int k = 0; k < n; k++) begin
			foreach (uv[i])
				case ($urandom_range(5))
					0: uv[i] = $urandom_range(3) == 0 ? 24'h000000 : 24'hffffff;
					1: uv[i] = 24'h800000 + 24'($urandom_range(4095)) - 24'd2048;
					default: uv[i] = $urandom;
				endcase
			if ($urandom_range(99) < 20)
				send_beat(CMD_LOAD, 6'($urandom), 18'($urandom), uv);
			else
				send_beat(CMD_SAMPLE, 6'($urandom), 18'($urandom), uv);
		end
	endtask

	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 300;
		test_random(120, 0, 0);
		drain();
		test_random(20, 0, 0);
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		out_ready  <= 1'b0;
		cmd        <= CMD_LOAD;
		coef_index <= '0;
		coef_value <= '0;
		{u0, u1, u2, u3, u4, u5, u6, u7} <= '0;
		errors = 0;
		cycles = 0;
		recv_hold = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		foreach (matrix[i]) matrix[i] = '0;
		horner_p = '{q24_const(64'd39, 64'd696830286653, 1),
			q24_const(64'd220, 64'd946098424520, 0),
			q24_const(64'd275, 64'd928510446968, 1),
			q24_const(64'd138, 64'd357751867269, 0),
			q24_const(64'd30, 64'd664798066147, 1),
			q24_const(64'd2, 64'd506628277459, 0)};
		horner_q = '{q24_const(64'd54, 64'd476098798224, 1),
			q24_const(64'd161, 64'd585836858040, 0),
			q24_const(64'd155, 64'd698979859886, 1),
			q24_const(64'd66, 64'd801311887719, 0),
			q24_const(64'd13, 64'd280681552885, 1)};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cleared_matrix();
		test_identity_extremes();
		test_coef_saturation();
		drain();
		test_random(340, 27, 81);
		test_random(340, 81, 27);
		test_random(340, 0, 0);
		test_backpressure();
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("correlated_gaussian_from_uniform_tb OK");
		else
			$display("correlated_gaussian_from_uniform_tb NOT OK");
		$finish;
	end

endmodule
